// ----- rtl/core/swig_pkg.sv -----
// Shared types, codes and constants of the structured window index generator.
package swig_pkg;

    // Field widths
    localparam int COORD_W         = 11;
    localparam int OUT_INDEX_W     = 32;
    localparam int STATUS_W        = 2;
    localparam int ORIENT_W        = 2;
    localparam int CFG_INDEX_W     = 2;
    localparam int NUM_BOUNDS      = 6;
    localparam int SLOT_W          = 3;
    localparam int INDEX_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Operand widths of the shared multipliers
    localparam int MUL_X_W = COORD_W + 1;
    localparam int MUL_Y_W = 2 * COORD_W;
    localparam int PROD_W  = MUL_X_W + MUL_Y_W + 1;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // Index kinds
    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    // Window orientation
    localparam logic [ORIENT_W-1:0] ORIENT_NONE = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_I    = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_J    = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_K    = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] STATUS_INDEX      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_PLANAR = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE       = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_I   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_J   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_K   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_KIND = 2'd3;

    // Bound slots within a window
    localparam logic [SLOT_W-1:0] BI_LO = 3'd0;
    localparam logic [SLOT_W-1:0] BI_HI = 3'd1;
    localparam logic [SLOT_W-1:0] BJ_LO = 3'd2;
    localparam logic [SLOT_W-1:0] BJ_HI = 3'd3;
    localparam logic [SLOT_W-1:0] BK_LO = 3'd4;
    localparam logic [SLOT_W-1:0] BK_HI = 3'd5;

    localparam logic [COORD_W-1:0] ONE_COORD     = 11'd1;
    localparam logic [COORD_W-1:0] FORCED_K_HIGH = 11'd2;

    typedef struct packed {
        logic [COORD_W-1:0] points_i;
        logic [COORD_W-1:0] points_j;
        logic [COORD_W-1:0] points_k;
        logic               point_kind;
    } cfg_t;

    typedef struct packed {
        logic                                op;
        logic [NUM_BOUNDS-1:0][COORD_W-1:0]  bounds;
        logic [ORIENT_W-1:0]                 orient;
    } item_t;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] point_index;
        logic                   last_point;
        logic [STATUS_W-1:0]    status;
    } result_t;

endpackage

// ----- rtl/core/structured_window_index_generator.sv -----
// Top level of the structured window index generator: configuration registers and wiring.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  input     | push / full        | op, win_{i,j,k}_{low,high}
//  result    | empty / pop        | point_index, last_point, status
//  config    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A next item that yields an index passes through the back end in steps: dequeue, two
// multiplier steps, final add. A planar load is dequeued, then takes two steps of the face
// offset product, then its sum. Status-only answers go to the result register at dequeue.
// The two shared multipliers set these step sequences. While a result waits unpopped the
// back end holds in its last step, and the 2-entry queue keeps accepting until it fills and raises full.
// Reset is asynchronous, active low; cfg_ready is always high.
module structured_window_index_generator #(
    parameter int INDEX_WIDTH = swig_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 op,
    input  logic [swig_pkg::COORD_W-1:0]         win_i_low,
    input  logic [swig_pkg::COORD_W-1:0]         win_i_high,
    input  logic [swig_pkg::COORD_W-1:0]         win_j_low,
    input  logic [swig_pkg::COORD_W-1:0]         win_j_high,
    input  logic [swig_pkg::COORD_W-1:0]         win_k_low,
    input  logic [swig_pkg::COORD_W-1:0]         win_k_high,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [swig_pkg::OUT_INDEX_W-1:0]     point_index,
    output logic                                 last_point,
    output logic [swig_pkg::STATUS_W-1:0]        status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swig_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [swig_pkg::COORD_W-1:0]         cfg_data
);

    localparam int ITEM_W = $bits(swig_pkg::item_t);

    swig_pkg::cfg_t    cfg_reg, cfg_next;
    swig_pkg::item_t   front_item;
    swig_pkg::item_t   q_item;
    logic [ITEM_W-1:0] q_rd_data;
    logic              q_empty, q_pop;
    swig_pkg::result_t res;
    logic              res_valid;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                swig_pkg::REG_POINTS_I:   cfg_next.points_i   = cfg_data;
                swig_pkg::REG_POINTS_J:   cfg_next.points_j   = cfg_data;
                swig_pkg::REG_POINTS_K:   cfg_next.points_k   = cfg_data;
                swig_pkg::REG_POINT_KIND: cfg_next.point_kind = cfg_data[0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.points_i   <= swig_pkg::ONE_COORD;
            cfg_reg.points_j   <= swig_pkg::ONE_COORD;
            cfg_reg.points_k   <= swig_pkg::ONE_COORD;
            cfg_reg.point_kind <= swig_pkg::KIND_FACE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    swig_front u_front (
        .op         (op),
        .win_i_low  (win_i_low),
        .win_i_high (win_i_high),
        .win_j_low  (win_j_low),
        .win_j_high (win_j_high),
        .win_k_low  (win_k_low),
        .win_k_high (win_k_high),
        .cfg        (cfg_reg),
        .item       (front_item)
    );

    swig_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (swig_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign q_item = q_rd_data;

    swig_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .pop       (pop)
    );

    assign empty       = !res_valid;
    assign point_index = res.point_index;
    assign last_point  = res.last_point;
    assign status      = res.status;

endmodule

// ----- rtl/core/swig_front.sv -----
// Front end: forms a queue item from the input fields and classifies the window.
module swig_front (
    input  logic                                  op,
    input  logic [swig_pkg::COORD_W-1:0]          win_i_low,
    input  logic [swig_pkg::COORD_W-1:0]          win_i_high,
    input  logic [swig_pkg::COORD_W-1:0]          win_j_low,
    input  logic [swig_pkg::COORD_W-1:0]          win_j_high,
    input  logic [swig_pkg::COORD_W-1:0]          win_k_low,
    input  logic [swig_pkg::COORD_W-1:0]          win_k_high,
    input  swig_pkg::cfg_t                        cfg,
    output swig_pkg::item_t                       item
);

    always_comb
    begin
        item                          = '0;
        item.op                       = op;
        item.bounds[swig_pkg::BI_LO]  = win_i_low;
        item.bounds[swig_pkg::BI_HI]  = win_i_high;
        item.bounds[swig_pkg::BJ_LO]  = win_j_low;
        item.bounds[swig_pkg::BJ_HI]  = win_j_high;
        item.bounds[swig_pkg::BK_LO]  = win_k_low;
        item.bounds[swig_pkg::BK_HI]  = win_k_high;

        // Force k high to 2 for a face window on a 2D block
        if (cfg.point_kind == swig_pkg::KIND_FACE && win_k_low == win_k_high &&
            cfg.points_k == swig_pkg::ONE_COORD)
        begin
            item.bounds[swig_pkg::BK_HI] = swig_pkg::FORCED_K_HIGH;
        end

        // Classify, i test first
        priority if (item.bounds[swig_pkg::BI_LO] == item.bounds[swig_pkg::BI_HI])
        begin
            item.orient = swig_pkg::ORIENT_I;
        end
        else if (item.bounds[swig_pkg::BJ_LO] == item.bounds[swig_pkg::BJ_HI])
        begin
            item.orient = swig_pkg::ORIENT_J;
        end
        else if (item.bounds[swig_pkg::BK_LO] == item.bounds[swig_pkg::BK_HI])
        begin
            item.orient = swig_pkg::ORIENT_K;
        end
        else
        begin
            item.orient = swig_pkg::ORIENT_NONE;
        end
    end

endmodule

// ----- rtl/core/swig_queue.sv -----
// Short register queue between the front end and the back end.
module swig_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/swig_back.sv -----
// Back end: window state, index sequencer with two shared multipliers, result register.
module swig_back #(
    parameter int INDEX_WIDTH = swig_pkg::INDEX_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swig_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  swig_pkg::item_t   q_item,
    output logic              q_pop,
    output swig_pkg::result_t res,
    output logic              res_valid,
    input  logic              pop
);

    localparam int CW = swig_pkg::COORD_W;
    localparam int XW = swig_pkg::MUL_X_W;
    localparam int YW = swig_pkg::MUL_Y_W;
    localparam int PW = swig_pkg::PROD_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LD1  = 3'd1;
    localparam logic [2:0] S_LD2  = 3'd2;
    localparam logic [2:0] S_LD3  = 3'd3;
    localparam logic [2:0] S_NX1  = 3'd4;
    localparam logic [2:0] S_NX2  = 3'd5;
    localparam logic [2:0] S_NX3  = 3'd6;

    function automatic logic [CW-1:0] at_least_one(input logic [CW-1:0] v);
        return (v > swig_pkg::ONE_COORD) ? v - swig_pkg::ONE_COORD : swig_pkg::ONE_COORD;
    endfunction

    function automatic logic signed [XW-1:0] minus_one(input logic [CW-1:0] c);
        return $signed({1'b0, c}) - 12'sd1;
    endfunction

    function automatic logic signed [XW-1:0] loop_last(input logic [CW-1:0] hi,
                                                       input logic kind);
        return (kind == swig_pkg::KIND_FACE) ? $signed({1'b0, hi}) - 12'sd1
                                             : $signed({1'b0, hi});
    endfunction

    function automatic logic [swig_pkg::SLOT_W-1:0] outer_slot(
        input logic [swig_pkg::ORIENT_W-1:0] orient);
        logic [swig_pkg::SLOT_W-1:0] s;
        s = ((orient == swig_pkg::ORIENT_I) || (orient == swig_pkg::ORIENT_J))
            ? swig_pkg::BK_LO : swig_pkg::BJ_LO;
        return s;
    endfunction

    function automatic logic [swig_pkg::SLOT_W-1:0] inner_slot(
        input logic [swig_pkg::ORIENT_W-1:0] orient);
        return (orient == swig_pkg::ORIENT_I) ? swig_pkg::BJ_LO : swig_pkg::BI_LO;
    endfunction

    function automatic logic [swig_pkg::SLOT_W-1:0] hi_slot(
        input logic [swig_pkg::SLOT_W-1:0] lo);
        return {lo[swig_pkg::SLOT_W-1:1], 1'b1};
    endfunction

    logic [2:0]                                       state_reg, state_next;
    logic [swig_pkg::NUM_BOUNDS-1:0][CW-1:0]          bounds_reg, bounds_next;
    logic [swig_pkg::ORIENT_W-1:0]                    orient_reg, orient_next;
    logic                                             kind_reg, kind_next;
    logic [CW-1:0]                                    outer_reg, outer_next;
    logic [CW-1:0]                                    inner_reg, inner_next;
    logic [INDEX_WIDTH-1:0]                           fo_reg, fo_next;
    logic                                             run_reg, run_next;
    logic signed [PW-1:0]                             prod_a_reg, prod_a_next;
    logic signed [PW-1:0]                             prod_b_reg, prod_b_next;
    logic [INDEX_WIDTH-1:0]                           part_reg, part_next;
    swig_pkg::result_t                                res_reg, res_next;
    logic                                             res_valid_reg, res_valid_next;

    logic signed [XW-1:0] mul_a_x, mul_b_x;
    logic [YW-1:0]        mul_a_y, mul_b_y;
    logic signed [PW-1:0] mul_a_p, mul_b_p;

    logic                 out_free;
    logic [CW-1:0]        ni1, nj1, nk1, m1, m2;
    logic                 face;
    logic signed [XW-1:0] term_a, term_b, term_c;
    logic signed [XW-1:0] n_m1, o_m1;
    logic [swig_pkg::SLOT_W-1:0] o_lo, n_lo, ld_o_lo, ld_n_lo;
    logic                 inner_end, outer_end, ld_run;
    logic [INDEX_WIDTH-1:0] idx;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign out_free  = !res_valid_reg || pop;

    // Shared multipliers
    assign mul_a_p = PW'(mul_a_x) * PW'($signed({1'b0, mul_a_y}));
    assign mul_b_p = PW'(mul_b_x) * PW'($signed({1'b0, mul_b_y}));

    // Derived sizes and loop terms
    always_comb
    begin
        ni1  = at_least_one(cfg.points_i);
        nj1  = at_least_one(cfg.points_j);
        nk1  = at_least_one(cfg.points_k);
        face = (kind_reg == swig_pkg::KIND_FACE);
        m1   = (face && orient_reg != swig_pkg::ORIENT_I) ? ni1 : cfg.points_i;
        m2   = (face && orient_reg != swig_pkg::ORIENT_J) ? nj1 : cfg.points_j;
        n_m1 = minus_one(inner_reg);
        o_m1 = minus_one(outer_reg);
        unique case (orient_reg)
            swig_pkg::ORIENT_I:
            begin
                term_a = minus_one(bounds_reg[swig_pkg::BI_LO]);
                term_b = n_m1;
                term_c = o_m1;
            end
            swig_pkg::ORIENT_J:
            begin
                term_a = n_m1;
                term_b = minus_one(bounds_reg[swig_pkg::BJ_LO]);
                term_c = o_m1;
            end
            swig_pkg::ORIENT_K:
            begin
                term_a = n_m1;
                term_b = o_m1;
                term_c = minus_one(bounds_reg[swig_pkg::BK_LO]);
            end
            default:
            begin
                term_a = '0;
                term_b = '0;
                term_c = '0;
            end
        endcase

        o_lo      = outer_slot(orient_reg);
        n_lo      = inner_slot(orient_reg);
        inner_end = $signed({1'b0, inner_reg}) >= loop_last(bounds_reg[hi_slot(n_lo)], kind_reg);
        outer_end = $signed({1'b0, outer_reg}) >= loop_last(bounds_reg[hi_slot(o_lo)], kind_reg);

        ld_o_lo = outer_slot(q_item.orient);
        ld_n_lo = inner_slot(q_item.orient);
        ld_run  = (loop_last(q_item.bounds[hi_slot(ld_o_lo)], cfg.point_kind) >=
                   $signed({1'b0, q_item.bounds[ld_o_lo]})) &&
                  (loop_last(q_item.bounds[hi_slot(ld_n_lo)], cfg.point_kind) >=
                   $signed({1'b0, q_item.bounds[ld_n_lo]}));

        idx = part_reg + INDEX_WIDTH'(prod_b_reg);
    end

    // Select multiplier operands per step
    always_comb
    begin
        mul_a_x = '0;
        mul_a_y = '0;
        mul_b_x = '0;
        mul_b_y = '0;
        unique case (state_reg)
            S_LD1:
            begin
                mul_a_x = $signed({1'b0, cfg.points_i});
                mul_a_y = YW'(nj1);
                mul_b_x = $signed({1'b0, ni1});
                mul_b_y = YW'(cfg.points_j);
            end
            S_LD2:
            begin
                mul_a_x = $signed({1'b0, nk1});
                mul_a_y = prod_a_reg[YW-1:0];
                mul_b_x = $signed({1'b0, nk1});
                mul_b_y = prod_b_reg[YW-1:0];
            end
            S_NX1:
            begin
                mul_a_x = term_b;
                mul_a_y = YW'(m1);
                mul_b_x = $signed({1'b0, m1});
                mul_b_y = YW'(m2);
            end
            S_NX2:
            begin
                mul_b_x = term_c;
                mul_b_y = prod_b_reg[YW-1:0];
            end
            default:
            begin
                mul_a_x = '0;
            end
        endcase
    end

    // Sequence items
    always_comb
    begin
        state_next     = state_reg;
        bounds_next    = bounds_reg;
        orient_next    = orient_reg;
        kind_next      = kind_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        fo_next        = fo_reg;
        run_next       = run_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        part_next      = part_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        q_pop          = 1'b0;

        // Drop the delivered result
        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_item.op == swig_pkg::OP_NEXT)
                    begin
                        if (run_reg)
                        begin
                            q_pop      = 1'b1;
                            state_next = S_NX1;
                        end
                        else if (out_free)
                        begin
                            q_pop          = 1'b1;
                            res_next       = '0;
                            res_next.status = swig_pkg::STATUS_NONE;
                            res_valid_next = 1'b1;
                        end
                    end
                    else if (q_item.orient == swig_pkg::ORIENT_NONE)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            orient_next    = swig_pkg::ORIENT_NONE;
                            run_next       = 1'b0;
                            res_next       = '0;
                            res_next.status = swig_pkg::STATUS_NOT_PLANAR;
                            res_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Latch the window and start the face offset
                        q_pop       = 1'b1;
                        bounds_next = q_item.bounds;
                        orient_next = q_item.orient;
                        kind_next   = cfg.point_kind;
                        outer_next  = q_item.bounds[ld_o_lo];
                        inner_next  = q_item.bounds[ld_n_lo];
                        run_next    = ld_run;
                        state_next  = S_LD1;
                    end
                end
            end
            S_LD1:
            begin
                prod_a_next = mul_a_p;
                prod_b_next = mul_b_p;
                state_next  = S_LD2;
            end
            S_LD2:
            begin
                prod_a_next = mul_a_p;
                prod_b_next = mul_b_p;
                state_next  = S_LD3;
            end
            S_LD3:
            begin
                if (out_free)
                begin
                    fo_next = '0;
                    if (kind_reg == swig_pkg::KIND_FACE)
                    begin
                        fo_next = ((orient_reg != swig_pkg::ORIENT_I)
                                   ? INDEX_WIDTH'(prod_a_reg) : '0) +
                                  ((orient_reg == swig_pkg::ORIENT_K)
                                   ? INDEX_WIDTH'(prod_b_reg) : '0);
                    end
                    res_next        = '0;
                    res_next.status = swig_pkg::STATUS_ACCEPT;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_NX1:
            begin
                prod_a_next = mul_a_p;
                prod_b_next = mul_b_p;
                state_next  = S_NX2;
            end
            S_NX2:
            begin
                prod_b_next = mul_b_p;
                part_next   = INDEX_WIDTH'(term_a) + INDEX_WIDTH'(prod_a_reg) + fo_reg;
                state_next  = S_NX3;
            end
            S_NX3:
            begin
                if (out_free)
                begin
                    res_next.point_index = swig_pkg::OUT_INDEX_W'(idx);
                    res_next.last_point  = inner_end && outer_end;
                    res_next.status      = swig_pkg::STATUS_INDEX;
                    res_valid_next       = 1'b1;
                    // Advance the loop counters
                    if (inner_end)
                    begin
                        inner_next = bounds_reg[n_lo];
                        if (outer_end)
                        begin
                            run_next = 1'b0;
                        end
                        else
                        begin
                            outer_next = outer_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        inner_next = inner_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bounds_reg    <= '0;
            orient_reg    <= swig_pkg::ORIENT_NONE;
            kind_reg      <= swig_pkg::KIND_FACE;
            outer_reg     <= '0;
            inner_reg     <= '0;
            fo_reg        <= '0;
            run_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bounds_reg    <= bounds_next;
            orient_reg    <= orient_next;
            kind_reg      <= kind_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            fo_reg        <= fo_next;
            run_reg       <= run_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        part_reg   <= part_next;
        res_reg    <= res_next;
    end

endmodule

// ----- rtl/core/swig_checker.sv -----
// Port-level checker of the structured window index generator and its bind.
module swig_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic [swig_pkg::OUT_INDEX_W-1:0] point_index,
    input logic                             last_point,
    input logic [swig_pkg::STATUS_W-1:0]    status
);

    localparam int OUTST_W = $clog2(swig_pkg::QUEUE_DEPTH + 3);

    logic [OUTST_W-1:0] outst_reg, outst_next;

    // Track transactions accepted but not yet delivered
    always_comb
    begin
        outst_next = outst_reg;
        if ((push && !full) && !(pop && !empty))
        begin
            outst_next = outst_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(point_index) && $stable(status) &&
                           $stable(last_point))
        else $error("waiting result changed before pop");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != swig_pkg::STATUS_INDEX |-> point_index == '0 && !last_point)
        else $error("status result carries index or last flag");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> outst_reg != '0)
        else $error("result shown with no transaction outstanding");

endmodule

bind structured_window_index_generator swig_checker u_swig_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench of the structured window index generator.
`timescale 1ns / 100ps

module tb;
    import swig_pkg::*;

    typedef bit [NUM_BOUNDS-1:0][COORD_W-1:0] bounds_t;

    localparam int CYCLE_LIMIT = 400000;

    // Tracks the window walk and holds the results still due from the block
    class window_walker;
        bit [COORD_W-1:0]     size_i;
        bit [COORD_W-1:0]     size_j;
        bit [COORD_W-1:0]     size_k;
        bit                   kind_cfg;
        bit [COORD_W-1:0]     win [NUM_BOUNDS];
        bit [ORIENT_W-1:0]    orient;
        bit [COORD_W-1:0]     outer_pos;
        bit [COORD_W-1:0]     inner_pos;
        bit [OUT_INDEX_W-1:0] face_base;
        bit                   walking;
        bit                   kind_held;
        result_t              due_results[$];
        int                   mismatches;

        function new();
            size_i = ONE_COORD;
            size_j = ONE_COORD;
            size_k = ONE_COORD;
            kind_cfg = KIND_FACE;
            foreach (win[s])
                win[s] = '0;
            orient = ORIENT_NONE;
            outer_pos = '0;
            inner_pos = '0;
            face_base = '0;
            walking = 1'b0;
            kind_held = KIND_FACE;
            mismatches = 0;
        endfunction

        function int due();
            return due_results.size();
        endfunction

        function void set_reg(bit [CFG_INDEX_W-1:0] idx, bit [COORD_W-1:0] data);
            case (idx)
                REG_POINTS_I:   size_i = data;
                REG_POINTS_J:   size_j = data;
                REG_POINTS_K:   size_k = data;
                REG_POINT_KIND: kind_cfg = data[0];
                default: ;
            endcase
        endfunction

        // Axis numbers 0, 1, 2 stand for i, j, k
        function void axes_of(output int outer_ax, output int inner_ax);
            outer_ax = (orient == ORIENT_I || orient == ORIENT_J) ? 2 : 1;
            inner_ax = (orient == ORIENT_I) ? 1 : 0;
        endfunction

        // Face loops stop one short of the high bound
        function longint last_of(int ax);
            longint hi;
            hi = longint'(win[2*ax+1]);
            return (kind_held == KIND_FACE) ? hi - 1 : hi;
        endfunction

        function bit [OUT_INDEX_W-1:0] index_now();
            longint ni, nj, ni1, nj1, o, n, fi, fj, fk, v;
            bit [63:0] wide;
            ni = longint'(size_i);
            nj = longint'(size_j);
            ni1 = (ni > 1) ? ni - 1 : 1;
            nj1 = (nj > 1) ? nj - 1 : 1;
            o = longint'(outer_pos) - 1;
            n = longint'(inner_pos) - 1;
            fi = longint'(win[BI_LO]) - 1;
            fj = longint'(win[BJ_LO]) - 1;
            fk = longint'(win[BK_LO]) - 1;
            if (kind_held == KIND_FACE)
            begin
                if (orient == ORIENT_I)
                    v = fi + n * ni + o * ni * nj1;
                else if (orient == ORIENT_J)
                    v = n + fj * ni1 + o * ni1 * nj;
                else
                    v = n + o * ni1 + fk * ni1 * nj1;
                v = v + longint'(face_base);
            end
            else
            begin
                if (orient == ORIENT_I)
                    v = fi + n * ni + o * ni * nj;
                else if (orient == ORIENT_J)
                    v = n + fj * ni + o * ni * nj;
                else
                    v = n + o * ni + fk * ni * nj;
            end
            wide = v;
            return wide[OUT_INDEX_W-1:0];
        endfunction

        // Advance the walk by one accepted transaction and queue its result
        function void take_item(bit item_op, bounds_t b);
            result_t r;
            int oa, ia;
            longint ni, nj, nk, ni1, nj1, nk1, off;
            bit [63:0] off_bits;
            bit inner_end, outer_end;
            r = '0;
            if (item_op == OP_LOAD)
            begin
                // a flat block in face mode gets one cell along k
                if (kind_cfg == KIND_FACE && b[BK_LO] == b[BK_HI] && size_k == ONE_COORD)
                    b[BK_HI] = FORCED_K_HIGH;
                if (b[BI_LO] == b[BI_HI])
                    orient = ORIENT_I;
                else if (b[BJ_LO] == b[BJ_HI])
                    orient = ORIENT_J;
                else if (b[BK_LO] == b[BK_HI])
                    orient = ORIENT_K;
                else
                    orient = ORIENT_NONE;
                if (orient == ORIENT_NONE)
                begin
                    walking = 1'b0;
                    r.status = STATUS_NOT_PLANAR;
                end
                else
                begin
                    foreach (win[s])
                        win[s] = b[s];
                    kind_held = kind_cfg;
                    face_base = '0;
                    if (kind_held == KIND_FACE)
                    begin
                        // i faces come first, then j faces, then k faces
                        ni = longint'(size_i);
                        nj = longint'(size_j);
                        nk = longint'(size_k);
                        ni1 = (ni > 1) ? ni - 1 : 1;
                        nj1 = (nj > 1) ? nj - 1 : 1;
                        nk1 = (nk > 1) ? nk - 1 : 1;
                        off = 0;
                        if (orient == ORIENT_J || orient == ORIENT_K)
                            off += ni * nj1 * nk1;
                        if (orient == ORIENT_K)
                            off += ni1 * nj * nk1;
                        off_bits = off;
                        face_base = off_bits[OUT_INDEX_W-1:0];
                    end
                    axes_of(oa, ia);
                    outer_pos = win[2*oa];
                    inner_pos = win[2*ia];
                    walking = (last_of(oa) >= longint'(outer_pos)) &&
                              (last_of(ia) >= longint'(inner_pos));
                    r.status = STATUS_ACCEPT;
                end
            end
            else if (!walking)
                r.status = STATUS_NONE;
            else
            begin
                axes_of(oa, ia);
                r.point_index = index_now();
                inner_end = longint'(inner_pos) >= last_of(ia);
                outer_end = longint'(outer_pos) >= last_of(oa);
                if (inner_end)
                begin
                    inner_pos = win[2*ia];
                    if (outer_end)
                        walking = 1'b0;
                    else
                        outer_pos = outer_pos + 1'b1;
                end
                else
                    inner_pos = inner_pos + 1'b1;
                r.last_point = inner_end && outer_end;
                r.status = STATUS_INDEX;
            end
            due_results.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task match_result(logic [OUT_INDEX_W-1:0] got_index, logic got_last,
                          logic [STATUS_W-1:0] got_status);
            result_t want;
            if (due_results.size() == 0)
                report($sformatf("result with none due: index %0d status %0d",
                                 got_index, got_status));
            else
            begin
                want = due_results.pop_front();
                if (got_status !== want.status)
                    report($sformatf("status %0d, want %0d", got_status, want.status));
                if (got_index !== want.point_index)
                    report($sformatf("point_index %0d, want %0d (status %0d)",
                                     got_index, want.point_index, want.status));
                if (got_last !== want.last_point)
                    report($sformatf("last_point %0b, want %0b (index %0d)",
                                     got_last, want.last_point, want.point_index));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   op = OP_LOAD;
    logic [COORD_W-1:0]     win_i_low = '0;
    logic [COORD_W-1:0]     win_i_high = '0;
    logic [COORD_W-1:0]     win_j_low = '0;
    logic [COORD_W-1:0]     win_j_high = '0;
    logic [COORD_W-1:0]     win_k_low = '0;
    logic [COORD_W-1:0]     win_k_high = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [OUT_INDEX_W-1:0] point_index;
    logic                   last_point;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_POINTS_I;
    logic [COORD_W-1:0]     cfg_data = '0;

    window_walker walker;
    bit           idle_on = 1'b1;
    int           cycles = 0;

    structured_window_index_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .win_i_low   (win_i_low),
        .win_i_high  (win_i_high),
        .win_j_low   (win_j_low),
        .win_j_high  (win_j_high),
        .win_k_low   (win_k_low),
        .win_k_high  (win_k_high),
        .empty       (empty),
        .pop         (pop),
        .point_index (point_index),
        .last_point  (last_point),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Take results and, while idling is on, stall the result side at random
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            walker.match_result(point_index, last_point, status);
        pop <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    function automatic bounds_t random_bounds();
        bounds_t b;
        for (int s = 0; s < NUM_BOUNDS; s++)
            b[s] = COORD_W'($urandom_range(0, 2047));
        return b;
    endfunction

    function automatic bit [COORD_W-1:0] pick_size();
        case ($urandom_range(7))
            0: return '0;
            1: return ONE_COORD;
            2: return COORD_W'(1024);
            3: return COORD_W'(2047);
            4: return COORD_W'($urandom_range(0, 2047));
            default: return COORD_W'($urandom_range(2, 10));
        endcase
    endfunction

    // Offer one transaction, hold it until the block takes it
    task automatic send_item(input bit item_op, input bounds_t b);
        while (idle_on && $urandom_range(99) < 33)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        op         <= item_op;
        win_i_low  <= b[BI_LO];
        win_i_high <= b[BI_HI];
        win_j_low  <= b[BJ_LO];
        win_j_high <= b[BJ_HI];
        win_k_low  <= b[BK_LO];
        win_k_high <= b[BK_HI];
        do @(posedge clk); while (full);
        walker.take_item(item_op, b);
    endtask

    task automatic load_win(input bit [COORD_W-1:0] il, ih, jl, jh, kl, kh);
        bounds_t b;
        b[BI_LO] = il;
        b[BI_HI] = ih;
        b[BJ_LO] = jl;
        b[BJ_HI] = jh;
        b[BK_LO] = kl;
        b[BK_HI] = kh;
        send_item(OP_LOAD, b);
    endtask

    // Bounds are don't-care on a next, so drive noise there
    task automatic next_items(input int count);
        repeat (count)
            send_item(OP_NEXT, random_bounds());
    endtask

    // Drop push and hold until every due result is back
    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge clk); while (walker.due() != 0);
    endtask

    task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        walker.set_reg(idx, data);
    endtask

    task automatic set_block(input bit [COORD_W-1:0] ni, nj, nk, kind_word);
        wait_idle();
        write_reg(REG_POINTS_I, ni);
        write_reg(REG_POINTS_J, nj);
        write_reg(REG_POINTS_K, nk);
        write_reg(REG_POINT_KIND, kind_word);
        cfg_valid <= 1'b0;
    endtask

    // Mostly planar windows walked with random length, plus broken loads, noise items and stray nexts
    task automatic random_phase(input int budget);
        int sent;
        int pick;
        int walk_len;
        int flat_axis;
        bit [COORD_W-1:0] lo;
        bounds_t b;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                flat_axis = $urandom_range(2);
                for (int a = 0; a < 3; a++)
                begin
                    case ($urandom_range(9))
                        0: lo = '0;
                        1: lo = COORD_W'($urandom_range(1000, 2043));
                        default: lo = COORD_W'($urandom_range(1, 6));
                    endcase
                    b[2*a] = lo;
                    if (a == flat_axis)
                        b[2*a+1] = lo;
                    else if (lo != 0 && $urandom_range(9) == 0)
                        b[2*a+1] = lo - 1'b1;
                    else
                        b[2*a+1] = lo + COORD_W'($urandom_range(0, 4));
                end
                send_item(OP_LOAD, b);
                walk_len = $urandom_range(1, 28);
                next_items(walk_len);
                sent += 1 + walk_len;
            end
            else if (pick < 80)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lo = COORD_W'($urandom_range(1, 2040));
                    b[2*a] = lo;
                    b[2*a+1] = lo + COORD_W'(1 + $urandom_range(0, 6));
                end
                send_item(OP_LOAD, b);
                sent += 1;
            end
            else if (pick < 92)
            begin
                send_item(1'($urandom_range(1)), random_bounds());
                sent += 1;
            end
            else
            begin
                walk_len = $urandom_range(1, 3);
                next_items(walk_len);
                sent += walk_len;
            end
        end
    endtask

    initial
    begin
        walker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset block: next with no window, flat block forcing, not planar
        next_items(1);
        load_win(1, 1, 1, 1, 1, 1);
        next_items(1);
        load_win(1, 2, 1, 2, 1, 2);

        // Flat block in face mode: forced k extent, full walk, then forced non-planar
        set_block(5, 4, 1, KIND_FACE);
        load_win(1, 1, 1, 4, 1, 1);
        next_items(4);
        load_win(1, 5, 1, 4, 1, 1);

        // Vertex mode: j plane, zero bound, k plane, empty window
        set_block(4, 3, 3, KIND_VERTEX);
        load_win(1, 4, 2, 2, 1, 3);
        next_items(2);
        load_win(0, 0, 1, 2, 1, 2);
        next_items(2);
        load_win(1, 2, 1, 2, 3, 3);
        next_items(1);
        load_win(1, 1, 3, 2, 1, 1);
        next_items(1);

        // Largest block and largest bounds in face mode
        set_block(1024, 1024, 1024, KIND_FACE);
        load_win(1023, 1024, 1023, 1024, 1024, 1024);
        next_items(2);
        load_win(2047, 2047, 0, 2047, 0, 2047);
        next_items(1);

        set_block(6, 5, 4, KIND_FACE);
        random_phase(90);
        set_block(3, 4, 1, KIND_FACE);
        random_phase(90);

        // Back-to-back stretch with no idling on either side
        set_block(2047, 2047, 2047, KIND_VERTEX);
        idle_on = 1'b0;
        random_phase(90);
        idle_on = 1'b1;

        // Pause the sender mid-phase until the block has drained
        set_block(1024, 1, 1024, KIND_VERTEX);
        random_phase(45);
        wait_idle();
        random_phase(45);

        for (int p = 0; p < 4; p++)
        begin
            set_block(pick_size(), pick_size(), pick_size(),
                      COORD_W'($urandom_range(0, 2047)));
            random_phase(90);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (walker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- structured_window_index_generator.f -----
rtl/core/swig_pkg.sv
rtl/core/swig_front.sv
rtl/core/swig_queue.sv
rtl/core/swig_back.sv
rtl/core/structured_window_index_generator.sv
rtl/core/swig_checker.sv
tb/tb.sv
